>>> rtl/hslc_pkg.sv
// shared constants and constant-divisor helpers for the hsl to rgba converter
package hslc_pkg;

  // default number of fraction bits of the internal fixed point
  localparam int unsigned FracBitsDef = 24;

  // field ranges, inputs saturate at these
  localparam logic [12:0] HueMax   = 13'd5760;
  localparam logic [10:0] PctMax   = 11'd1600;
  localparam logic [12:0] AlphaMax = 13'd4096;

  // register stages from an accepted word to its result
  localparam int unsigned PipeLat = 9;

  // hue phase of each color channel, in sixths of a turn
  localparam logic [2:0] PhaseRed   = 3'd0;
  localparam logic [2:0] PhaseGreen = 3'd4;
  localparam logic [2:0] PhaseBlue  = 3'd2;

  // floor(v / 15) for any 13-bit v, by reciprocal multiply
  function automatic logic [9:0] div15(input logic [12:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd8739;
    return p[26:17];
  endfunction

  // floor(v / 25) for any 11-bit v, by reciprocal multiply
  function automatic logic [6:0] div25(input logic [10:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd2622;
    return p[22:16];
  endfunction

endpackage

>>> rtl/hslc_norm.sv
// input saturation and fixed-point normalization of hue, saturation, lightness and alpha
module hslc_norm import hslc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic [12:0]            hue_i,
  input  logic [10:0]            sat_i,
  input  logic [10:0]            lit_i,
  input  logic [12:0]            alpha_i,
  output logic [FRAC_BITS+2:0]   h6_o,
  output logic [FRAC_BITS:0]     s_o,
  output logic [FRAC_BITS:0]     l_o,
  output logic [7:0]             alpha_o
);

  // x * 2^F / 960 is (x * 2^K + carry) / 15 with K = F - 6, likewise 1600 = 64 * 25
  localparam int unsigned K    = FRAC_BITS - 6;
  localparam int unsigned OneW = FRAC_BITS + 1;
  localparam int unsigned H6W  = FRAC_BITS + 3;
  localparam longint unsigned Q15 = (64'd1 << K) / 64'd15;
  localparam longint unsigned R15 = (64'd1 << K) % 64'd15;
  localparam longint unsigned Q25 = (64'd1 << K) / 64'd25;
  localparam longint unsigned R25 = (64'd1 << K) % 64'd25;

  // stage 1: saturate fields, coarse quotients, alpha byte
  logic [12:0] hue_c;
  logic [10:0] sat_c, lit_c;
  logic [12:0] alp_c;
  logic [20:0] alp_scaled;

  always_comb begin
    hue_c      = (hue_i > HueMax) ? HueMax : hue_i;
    sat_c      = (sat_i > PctMax) ? PctMax : sat_i;
    lit_c      = (lit_i > PctMax) ? PctMax : lit_i;
    alp_c      = (alpha_i > AlphaMax) ? AlphaMax : alpha_i;
    alp_scaled = 21'(alp_c) * 21'd255 + 21'd2048;
  end

  logic [12:0] hue1_q;
  logic [8:0]  hq1_q;
  logic [10:0] sat1_q, lit1_q;
  logic [6:0]  sq1_q, lq1_q;
  logic [7:0]  alp1_q;

  always_ff @(posedge clk_i) begin
    hue1_q <= hue_c;
    hq1_q  <= 9'(div15(hue_c));
    sat1_q <= sat_c;
    sq1_q  <= div25(sat_c);
    lit1_q <= lit_c;
    lq1_q  <= div25(lit_c);
    alp1_q <= alp_scaled[19:12];
  end

  // stage 2: remainders of the coarse division
  logic [8:0] hq2_q;
  logic [3:0] hb2_q;
  logic [6:0] sq2_q, lq2_q;
  logic [4:0] sb2_q, lb2_q;
  logic [7:0] alp2_q;

  always_ff @(posedge clk_i) begin
    hq2_q  <= hq1_q;
    hb2_q  <= 4'(hue1_q - 13'(hq1_q) * 13'd15);
    sq2_q  <= sq1_q;
    sb2_q  <= 5'(sat1_q - 11'(sq1_q) * 11'd25);
    lq2_q  <= lq1_q;
    lb2_q  <= 5'(lit1_q - 11'(lq1_q) * 11'd25);
    alp2_q <= alp1_q;
  end

  // stage 3: scaled quotient plus remainder share, and the leftover numerator
  logic [H6W-1:0]  hbase3_q;
  logic [12:0]     hv3_q;
  logic [OneW-1:0] sbase3_q, lbase3_q;
  logic [10:0]     sv3_q, lv3_q;
  logic [7:0]      alp3_q;

  always_ff @(posedge clk_i) begin
    hbase3_q <= (H6W'(hq2_q) << K) + H6W'(hb2_q) * H6W'(Q15);
    hv3_q    <= 13'(hb2_q) * 13'(R15) + 13'd7;
    sbase3_q <= (OneW'(sq2_q) << K) + OneW'(sb2_q) * OneW'(Q25);
    sv3_q    <= 11'(sb2_q) * 11'(R25) + 11'd12;
    lbase3_q <= (OneW'(lq2_q) << K) + OneW'(lb2_q) * OneW'(Q25);
    lv3_q    <= 11'(lb2_q) * 11'(R25) + 11'd12;
    alp3_q   <= alp2_q;
  end

  // stage 4: add the quotient of the leftover numerator
  logic [H6W-1:0]  h6_q;
  logic [OneW-1:0] s_q, l_q;
  logic [7:0]      alp4_q;

  always_ff @(posedge clk_i) begin
    h6_q   <= hbase3_q + H6W'(div15(hv3_q));
    s_q    <= sbase3_q + OneW'(div25(sv3_q));
    l_q    <= lbase3_q + OneW'(div25(lv3_q));
    alp4_q <= alp3_q;
  end

  assign h6_o    = h6_q;
  assign s_o     = s_q;
  assign l_o     = l_q;
  assign alpha_o = alp4_q;

endmodule

>>> rtl/hslc_mod.sv
// chroma amplitude: saturation times one minus |2l - 1|, rounded
module hslc_mod import hslc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic [FRAC_BITS:0] s_i,
  input  logic [FRAC_BITS:0] l_i,
  output logic [FRAC_BITS:0] m_o,
  output logic [FRAC_BITS:0] l_o
);

  localparam int unsigned OneW = FRAC_BITS + 1;
  localparam int unsigned PW   = 2 * OneW;
  localparam logic [OneW-1:0]      One   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] HalfF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // stage 5: lightness factor
  logic [OneW:0] twol, one_x, dev;
  logic [OneW-1:0] factor;

  always_comb begin
    twol   = {l_i, 1'b0};
    one_x  = {1'b0, One};
    dev    = (twol >= one_x) ? (twol - one_x) : (one_x - twol);
    factor = (dev >= one_x) ? '0 : OneW'(one_x - dev);
  end

  logic [OneW-1:0] factor5_q, s5_q, l5_q;

  always_ff @(posedge clk_i) begin
    factor5_q <= factor;
    s5_q      <= s_i;
    l5_q      <= l_i;
  end

  // stage 6: rounded product
  logic [PW-1:0] prod;

  assign prod = PW'(s5_q) * PW'(factor5_q) + PW'(HalfF);

  logic [OneW-1:0] m6_q, l6_q;

  always_ff @(posedge clk_i) begin
    m6_q <= prod[FRAC_BITS +: OneW];
    l6_q <= l5_q;
  end

  assign m_o = m6_q;
  assign l_o = l6_q;

endmodule

>>> rtl/hslc_chan.sv
// one color channel: clamped triangle wave of hue, scaled, offset by lightness, to a byte
module hslc_chan import hslc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic [2:0]           phase_i,
  input  logic [FRAC_BITS+2:0] h6_i,
  input  logic [FRAC_BITS:0]   m_i,
  input  logic [FRAC_BITS:0]   l_i,
  output logic [7:0]           byte_o
);

  localparam int unsigned OneW = FRAC_BITS + 1;
  localparam int unsigned H6W  = FRAC_BITS + 3;
  localparam int unsigned XW   = FRAC_BITS + 4;
  localparam int unsigned DW   = FRAC_BITS + 2;
  localparam int unsigned PW   = 2 * FRAC_BITS + 1;
  localparam int unsigned BW   = FRAC_BITS + 9;
  localparam logic [XW-1:0]        Six      = XW'(6) << FRAC_BITS;
  localparam logic [H6W-1:0]       Three    = H6W'(3) << FRAC_BITS;
  localparam logic [DW-1:0]        ThreeHlf = DW'(3) << (FRAC_BITS - 1);
  localparam logic [DW-1:0]        HalfD    = DW'(1) << (FRAC_BITS - 1);
  localparam logic [OneW-1:0]      One      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] HalfF    = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // stage 5: phase shift and reduction modulo six
  logic [XW-1:0] x_sum, x_red;

  always_comb begin
    x_sum = XW'(h6_i) + {1'b0, phase_i, {FRAC_BITS{1'b0}}};
    x_red = (x_sum >= Six) ? (x_sum - Six) : x_sum;
  end

  logic [H6W-1:0] x5_q;

  always_ff @(posedge clk_i) begin
    x5_q <= H6W'(x_red);
  end

  // stage 6: triangle wave, clamped to plus or minus one half, as sign and magnitude
  logic [DW-1:0] d, raw, mag;
  logic          neg;

  always_comb begin
    d = (x5_q >= Three) ? DW'(x5_q - Three) : DW'(Three - x5_q);
    if (d >= ThreeHlf) begin
      neg = 1'b0;
      raw = d - ThreeHlf;
    end else begin
      neg = 1'b1;
      raw = ThreeHlf - d;
    end
    mag = (raw > HalfD) ? HalfD : raw;
  end

  logic [FRAC_BITS-1:0] mag6_q;
  logic                 neg6_q;

  always_ff @(posedge clk_i) begin
    mag6_q <= FRAC_BITS'(mag);
    neg6_q <= neg;
  end

  // stage 7: rounded product with the chroma amplitude
  logic [PW-1:0] prod;

  assign prod = PW'(m_i) * PW'(mag6_q) + PW'(HalfF);

  logic [FRAC_BITS-1:0] p7_q;
  logic                 neg7_q;
  logic [OneW-1:0]      l7_q;

  always_ff @(posedge clk_i) begin
    p7_q   <= prod[FRAC_BITS +: FRAC_BITS];
    neg7_q <= neg6_q;
    l7_q   <= l_i;
  end

  // stage 8: add to lightness and saturate to zero..one
  logic [DW-1:0]   lw, pw, csum;
  logic [OneW-1:0] c;

  always_comb begin
    lw = DW'(l7_q);
    pw = DW'(p7_q);
    if (neg7_q) begin
      csum = (pw > lw) ? '0 : (lw - pw);
    end else begin
      csum = lw + pw;
    end
    c = (csum > DW'(One)) ? One : OneW'(csum);
  end

  logic [OneW-1:0] c8_q;

  always_ff @(posedge clk_i) begin
    c8_q <= c;
  end

  // stage 9: times 255, round half up
  logic [BW-1:0] bw, bsum;

  always_comb begin
    bw   = BW'(c8_q);
    bsum = (bw << 8) - bw + BW'(HalfF);
  end

  logic [7:0] byte9_q;

  always_ff @(posedge clk_i) begin
    byte9_q <= bsum[FRAC_BITS +: 8];
  end

  assign byte_o = byte9_q;

endmodule

>>> rtl/hsl_to_rgba_converter_top.sv
// hsl plus alpha to rgba bytes, nine-stage pipeline
// a word accepted on start_i gives its result on done_o once it has passed all nine register stages
// throughput: one word per cycle; busy_o is always low, there is no stall anywhere
// the rate is set by the nine register stages, each holding at most one multiply
// reset clears only the valid pipeline; a word in flight at reset is dropped
// the receiver cannot stall: each result stands for exactly one cycle
module hsl_to_rgba_converter_top import hslc_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [12:0] hue_sixteenths_i,
  input  logic [10:0] saturation_sixteenths_i,
  input  logic [10:0] lightness_sixteenths_i,
  input  logic [12:0] alpha_fraction_i,
  output logic        done_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o
);

  localparam int unsigned AlphaDly = PipeLat - 4;

  // the pipeline never stalls
  assign busy_o = 1'b0;

  // valid bits travel with each word
  logic [PipeLat-1:0] vld_d, vld_q;

  assign vld_d = {vld_q[PipeLat-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // normalization, stages one to four
  logic [FRAC_BITS+2:0] h6;
  logic [FRAC_BITS:0]   s_n, l_n, m_a, l_a;
  logic [7:0]           alpha_n;

  hslc_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i   (clk_i),
    .hue_i   (hue_sixteenths_i),
    .sat_i   (saturation_sixteenths_i),
    .lit_i   (lightness_sixteenths_i),
    .alpha_i (alpha_fraction_i),
    .h6_o    (h6),
    .s_o     (s_n),
    .l_o     (l_n),
    .alpha_o (alpha_n)
  );

  // chroma amplitude, stages five and six
  hslc_mod #(.FRAC_BITS(FRAC_BITS)) u_mod (
    .clk_i (clk_i),
    .s_i   (s_n),
    .l_i   (l_n),
    .m_o   (m_a),
    .l_o   (l_a)
  );

  // color channels, stages five to nine
  hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_r (
    .clk_i   (clk_i),
    .phase_i (PhaseRed),
    .h6_i    (h6),
    .m_i     (m_a),
    .l_i     (l_a),
    .byte_o  (red_o)
  );

  hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_g (
    .clk_i   (clk_i),
    .phase_i (PhaseGreen),
    .h6_i    (h6),
    .m_i     (m_a),
    .l_i     (l_a),
    .byte_o  (green_o)
  );

  hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_b (
    .clk_i   (clk_i),
    .phase_i (PhaseBlue),
    .h6_i    (h6),
    .m_i     (m_a),
    .l_i     (l_a),
    .byte_o  (blue_o)
  );

  // alpha byte delay line to line up with the color channels
  logic [7:0] alpha_q [AlphaDly];

  always_ff @(posedge clk_i) begin
    alpha_q[0] <= alpha_n;
    for (int i = 1; i < AlphaDly; i++) begin
      alpha_q[i] <= alpha_q[i-1];
    end
  end

  assign alpha_o = alpha_q[AlphaDly-1];
  assign done_o  = vld_q[PipeLat-1];

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##PipeLat done_o)
    else $error("accepted word did not complete after pipeline latency");

  // zero saturation gives a gray
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && saturation_sixteenths_i == 11'd0 |-> ##PipeLat
    (red_o == green_o && green_o == blue_o))
    else $error("zero saturation did not give equal channels");

  // full lightness gives white whatever the hue and saturation
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && lightness_sixteenths_i >= PctMax |-> ##PipeLat
    (red_o == 8'hFF && green_o == 8'hFF && blue_o == 8'hFF))
    else $error("full lightness did not give white");

  // full opacity gives alpha byte 255
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && alpha_fraction_i >= AlphaMax |-> ##PipeLat
    alpha_o == 8'hFF)
    else $error("full opacity did not give alpha 255");

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the hsl to rgba converter: directed table, then random colors
module tb_top;
  import hslc_pkg::*;

  localparam int unsigned Frac       = FracBitsDef;
  localparam longint      One        = 64'sd1 <<< Frac;
  localparam int unsigned NumRandom  = 1250;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned NumRows    = 20;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [12:0] hue;
    logic [10:0] sat;
    logic [10:0] light;
    logic [12:0] alpha;
    logic        known;
    rgba_t       color;
  } color_row_t;

  // directed colors; rows with known set carry their expected bytes
  localparam color_row_t ColorRows [NumRows] = '{
    '{13'd0,    11'd0,    11'd0,    13'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
    '{13'd0,    11'd0,    11'd1600, 13'd4096, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{13'd8191, 11'd2047, 11'd2047, 13'd8191, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{13'd0,    11'd1600, 11'd800,  13'd4096, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd255}},
    '{13'd1920, 11'd1600, 11'd800,  13'd0,    1'b1, '{8'd0,   8'd255, 8'd0,   8'd0}},
    '{13'd3840, 11'd1600, 11'd800,  13'd2048, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd128}},
    '{13'd5760, 11'd1600, 11'd800,  13'd4096, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd255}},
    '{13'd960,  11'd1600, 11'd800,  13'd4095, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd255}},
    '{13'd2000, 11'd0,    11'd800,  13'd2048, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd128}},
    '{13'd5761, 11'd1600, 11'd800,  13'd1,    1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
    '{13'd1234, 11'd2047, 11'd0,    13'd8191, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
    '{13'd1,    11'd1,    11'd1,    13'd1,    1'b0, '0},
    '{13'd5759, 11'd1599, 11'd1599, 13'd4095, 1'b0, '0},
    '{13'd480,  11'd1600, 11'd400,  13'd3000, 1'b0, '0},
    '{13'd2880, 11'd800,  11'd1200, 13'd100,  1'b0, '0},
    '{13'd4800, 11'd1600, 11'd1599, 13'd4097, 1'b0, '0},
    '{13'd7000, 11'd1000, 11'd2047, 13'd4097, 1'b0, '0},
    '{13'd4096, 11'd1024, 11'd1024, 13'd4096, 1'b0, '0},
    '{13'd3200, 11'd1600, 11'd800,  13'd2047, 1'b0, '0},
    '{13'd640,  11'd1234, 11'd321,  13'd777,  1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [12:0] hue;
  logic [10:0] sat;
  logic [10:0] light;
  logic [12:0] alpha_frac;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha_byte;

  // expected bytes of the word being driven, when typed in by the table
  logic        word_known;
  rgba_t       word_color;

  rgba_t       pending_colors[$];
  int unsigned words_taken;
  int unsigned colors_checked;
  int unsigned idle_cycles;
  int unsigned fails;

  hsl_to_rgba_converter_top DUT (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .start_i                 (start),
    .busy_o                  (busy),
    .hue_sixteenths_i        (hue),
    .saturation_sixteenths_i (sat),
    .lightness_sixteenths_i  (light),
    .alpha_fraction_i        (alpha_frac),
    .done_o                  (done),
    .red_o                   (red),
    .green_o                 (green),
    .blue_o                  (blue),
    .alpha_o                 (alpha_byte)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one color channel: clamped triangle wave, scaled by chroma, lightness added
  function automatic logic [7:0] channel_byte(longint h6, logic [2:0] phase, longint m,
                                              longint l);
    longint x;
    longint d;
    longint t;
    longint mag;
    longint p;
    longint c;
    x = (h6 + longint'(phase) * One) % (6 * One);
    d = x - 3 * One;
    if (d < 0) d = -d;
    t = d - (3 * One) / 2;
    if (t < -(One / 2)) t = -(One / 2);
    if (t > One / 2) t = One / 2;
    mag = (t < 0) ? -t : t;
    p = (m * mag + One / 2) >>> Frac;
    c = (t < 0) ? l - p : l + p;
    if (c < 0) c = 0;
    if (c > One) c = One;
    return 8'((c * 255 + One / 2) >>> Frac);
  endfunction

  // expected rgba bytes for one hsl plus alpha word
  function automatic rgba_t hsl_to_rgba_bytes(logic [12:0] hue_raw, logic [10:0] sat_raw,
                                              logic [10:0] light_raw, logic [12:0] alpha_raw);
    rgba_t  color;
    longint h;
    longint s_pct;
    longint l_pct;
    longint a;
    longint h6;
    longint s;
    longint l;
    longint dev;
    longint factor;
    longint m;
    h     = (hue_raw > HueMax) ? longint'(HueMax) : longint'(hue_raw);
    s_pct = (sat_raw > PctMax) ? longint'(PctMax) : longint'(sat_raw);
    l_pct = (light_raw > PctMax) ? longint'(PctMax) : longint'(light_raw);
    a     = (alpha_raw > AlphaMax) ? longint'(AlphaMax) : longint'(alpha_raw);
    h6 = ((h <<< Frac) + 480) / 960;
    s  = ((s_pct <<< Frac) + 800) / 1600;
    l  = ((l_pct <<< Frac) + 800) / 1600;
    dev = 2 * l - One;
    if (dev < 0) dev = -dev;
    factor = (dev >= One) ? 0 : One - dev;
    m = (s * factor + One / 2) >>> Frac;
    color.red   = channel_byte(h6, PhaseRed, m, l);
    color.green = channel_byte(h6, PhaseGreen, m, l);
    color.blue  = channel_byte(h6, PhaseBlue, m, l);
    color.alpha = 8'((a * 255 + 2048) >>> 12);
    return color;
  endfunction

  // random field value: mostly in range, some edges, some over the full width
  function automatic logic [12:0] pick_field(int unsigned max_val, int unsigned width);
    logic [12:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 13'd1;
          2: v = 13'(max_val - 1);
          default: v = 13'(max_val);
        endcase
      end
      1: v = 13'($urandom_range(0, (1 << width) - 1));
      default: v = 13'($urandom_range(0, max_val));
    endcase
    return v;
  endfunction

  task automatic compare_byte(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  // result check, input capture and watchdog, all on the rising edge
  always @(posedge clk) begin
    rgba_t want;
    if (rst_n) begin
      if (done) begin
        if (pending_colors.size() == 0) begin
          $error("result word with no input word pending");
          fails++;
        end else begin
          want = pending_colors.pop_front();
          compare_byte("red", want.red, red);
          compare_byte("green", want.green, green);
          compare_byte("blue", want.blue, blue);
          compare_byte("alpha", want.alpha, alpha_byte);
          colors_checked++;
        end
      end
      if (start && !busy) begin
        if (word_known) pending_colors.push_back(word_color);
        else pending_colors.push_back(hsl_to_rgba_bytes(hue, sat, light, alpha_frac));
        words_taken++;
      end
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles", StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // drive one word after a gap, return at the falling edge after it is taken
  task automatic send_word(logic [12:0] h, logic [10:0] s, logic [10:0] l, logic [12:0] a,
                           logic known, rgba_t color, int unsigned gap);
    int unsigned taken_before;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    hue        = h;
    sat        = s;
    light      = l;
    alpha_frac = a;
    word_known = known;
    word_color = color;
    taken_before = words_taken;
    do @(negedge clk); while (words_taken == taken_before);
  endtask

  // stimulus
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    rst_n = 1'b0;
    start = 1'b0;
    hue = '0;
    sat = '0;
    light = '0;
    alpha_frac = '0;
    word_known = 1'b0;
    word_color = '0;
    words_taken = 0;
    colors_checked = 0;
    idle_cycles = 0;
    fails = 0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int i = 0; i < NumRows; i++) begin
      send_word(ColorRows[i].hue, ColorRows[i].sat, ColorRows[i].light, ColorRows[i].alpha,
                ColorRows[i].known, ColorRows[i].color, $urandom_range(0, 3));
    end

    // random colors, with back-to-back bursts between gapped stretches
    for (int i = 0; i < NumRandom; i++) begin
      if (burst_left == 0 && $urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 60);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, 17);
      end
      send_word(pick_field(32'(HueMax), 13), 11'(pick_field(32'(PctMax), 11)),
                11'(pick_field(32'(PctMax), 11)), pick_field(32'(AlphaMax), 13), 1'b0, '0,
                gap);
    end
    start = 1'b0;

    // drain the pipeline, then give stray results a chance to show up
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (PipeLat + 4) @(negedge clk);

    $display("covered %0d directed and %0d random colors, %0d results checked",
             NumRows, NumRandom, colors_checked);
    $display("fields included out-of-range values, full turns and primary hues");
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
